### rtl/set_assoc_lru_cache_tags_unit_macros.svh
// assertion macros for the set-associative cache tag unit
// used by rtl files that carry concurrent assertions; expects i_clk and i_rst_n in scope
`ifndef SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_UNIT_MACROS_SVH

// same-cycle implication
`define SALC_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define SALC_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/salc_pkg.sv
// shared types, constants and helpers of the set-associative cache tag unit
// no dependencies
package salc_pkg;

    localparam int DEF_MAX_SETS  = 256;
    localparam int DEF_MAX_WAYS  = 8;
    localparam int DEF_ADDR_BITS = 32;

    localparam int ADDR_W     = 32;
    localparam int OFF_W      = 5;
    localparam int IB_W       = 4;
    localparam int WAYS_W     = 4;
    localparam int WAY_OUT_W  = 3;
    localparam int REFS_W     = 2;
    localparam int CFG_ADDR_W = 4;
    localparam int CFG_DATA_W = 32;

    localparam logic [OFF_W-1:0]  OFF_RESET  = 5'd4;
    localparam logic [IB_W-1:0]   IB_RESET   = 4'd0;
    localparam logic [WAYS_W-1:0] WAYS_RESET = 4'd1;

    localparam logic [REFS_W-1:0] REFS_NONE = 2'd0;
    localparam logic [REFS_W-1:0] REFS_ONE  = 2'd1;
    localparam logic [REFS_W-1:0] REFS_TWO  = 2'd2;

    typedef enum logic [1:0] {
        REG_WRITE_BACK_MODE,
        REG_OFFSET_BITS,
        REG_INDEX_BITS,
        REG_WAYS_IN_USE
    } t_reg_idx;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_LOOK,
        S_WRITE
    } t_state;

    typedef struct packed {
        logic              hit;
        logic              fill;
        logic              dirty_ev;
        logic [REFS_W-1:0] refs;
    } t_decision;

    function automatic int max_index_bits(input int sets);
        int b;
        b = 0;
        while (b < 20 && (1 << (b + 1)) <= sets) begin
            b++;
        end
        return b;
    endfunction

endpackage

### rtl/set_assoc_lru_cache_tags_unit.sv
// Set-associative cache tag, dirty and LRU controller. Each set is one row of a
// simple dual-port synchronous memory. A transaction's row is read at the edge that
// accepts it. The lookup decides in the next cycle, and the row is written back in state
// S_WRITE once the output is free. The write-back of one transaction overlaps the read of
// the next (a same-set read is forwarded). The result enters the output register at the
// same edge as the write-back. While a result waits on i_ready, the write-back and the
// next acceptance wait with it.
// After reset a clearing pass initializes every row before the first transaction is
// accepted; configuration writes are taken meanwhile.
// Depends on salc_pkg, salc_lookup and set_assoc_lru_cache_tags_unit_macros.svh.
`include "set_assoc_lru_cache_tags_unit_macros.svh"

module set_assoc_lru_cache_tags_unit #(
    parameter int MAX_SETS  = salc_pkg::DEF_MAX_SETS,
    parameter int MAX_WAYS  = salc_pkg::DEF_MAX_WAYS,
    parameter int ADDR_BITS = salc_pkg::DEF_ADDR_BITS
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [salc_pkg::CFG_ADDR_W-1:0]     paddr,
    input  logic [salc_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [salc_pkg::CFG_DATA_W-1:0]     prdata,
    output logic                                pready,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic                                i_operation,
    input  logic [salc_pkg::ADDR_W-1:0]         i_address,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_hit,
    output logic [salc_pkg::WAY_OUT_W-1:0]      o_way,
    output logic [salc_pkg::REFS_W-1:0]         o_memory_refs,
    output logic                                o_dirty_evicted
);

    localparam int TAG_W    = (ADDR_BITS < salc_pkg::ADDR_W) ? ADDR_BITS : salc_pkg::ADDR_W;
    localparam int SET_W    = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
    localparam int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W   = $clog2(MAX_WAYS + 1);
    localparam int ROW_W    = MAX_WAYS * (TAG_W + RANK_W + 2);
    localparam int IB_MAX   = salc_pkg::max_index_bits(MAX_SETS);
    localparam logic [RANK_W-1:0] RANK_MAX = RANK_W'(MAX_WAYS - 1);
    localparam logic [SET_W-1:0]  SET_LAST = SET_W'(MAX_SETS - 1);

    // configuration
    logic                          r_wb;
    logic [salc_pkg::OFF_W-1:0]    r_off;
    logic [salc_pkg::IB_W-1:0]     r_ib;
    logic [salc_pkg::WAYS_W-1:0]   r_ways;
    logic                          cfg_we;
    salc_pkg::t_reg_idx            cfg_idx;

    // control
    salc_pkg::t_state              r_state;
    salc_pkg::t_state              n_state;
    logic [SET_W-1:0]              r_clr;
    logic                          in_acc;
    logic                          out_free;
    logic                          out_load;
    logic                          r_fwd;

    // memory
    logic [ROW_W-1:0]              r_mem [MAX_SETS];
    logic [ROW_W-1:0]              r_rd;
    logic                          mem_we;
    logic [SET_W-1:0]              mem_wa;
    logic [ROW_W-1:0]              mem_wd;
    logic [ROW_W-1:0]              r_fwd_row;
    logic [ROW_W-1:0]              row_look;

    // transaction
    logic [TAG_W-1:0]              addr_m;
    logic [salc_pkg::IB_W-1:0]     ib_eff;
    logic [5:0]                    shamt;
    logic [TAG_W-1:0]              tag_in;
    logic [TAG_W-1:0]              set_full;
    logic [SET_W-1:0]              set_in;
    logic [4:0]                    ways_wide;
    logic [WCNT_W-1:0]             ways_eff;
    logic [MAX_WAYS-1:0]           in_use;
    logic [TAG_W-1:0]              r_tag;
    logic [SET_W-1:0]              r_set;
    logic                          r_op;

    // row fields
    logic [MAX_WAYS-1:0]               l_v, l_d, r_v, r_d, n_v, n_d;
    logic [MAX_WAYS-1:0][RANK_W-1:0]   l_rk, r_rk, n_rk;
    logic [MAX_WAYS-1:0][TAG_W-1:0]    l_tg, r_tg, n_tg;
    logic [ROW_W-1:0]                  n_row;

    salc_pkg::t_decision           lk_dec;
    logic [WAY_W-1:0]              lk_way;
    logic                          touch;
    logic [WAY_W+2:0]              way_ext;

    // output register
    logic                          r_out_valid;
    logic                          r_out_hit;
    logic [salc_pkg::WAY_OUT_W-1:0] r_out_way;
    logic [salc_pkg::REFS_W-1:0]   r_out_refs;
    logic                          r_out_dev;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = salc_pkg::t_reg_idx'(paddr[3:2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wb   <= 1'b0;
            r_off  <= salc_pkg::OFF_RESET;
            r_ib   <= salc_pkg::IB_RESET;
            r_ways <= salc_pkg::WAYS_RESET;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                salc_pkg::REG_WRITE_BACK_MODE: r_wb   <= pwdata[0];
                salc_pkg::REG_OFFSET_BITS:     r_off  <= pwdata[salc_pkg::OFF_W-1:0];
                salc_pkg::REG_INDEX_BITS:      r_ib   <= pwdata[salc_pkg::IB_W-1:0];
                salc_pkg::REG_WAYS_IN_USE:     r_ways <= pwdata[salc_pkg::WAYS_W-1:0];
                default:                       r_wb   <= r_wb;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            salc_pkg::REG_WRITE_BACK_MODE: prdata = salc_pkg::CFG_DATA_W'(r_wb);
            salc_pkg::REG_OFFSET_BITS:     prdata = salc_pkg::CFG_DATA_W'(r_off);
            salc_pkg::REG_INDEX_BITS:      prdata = salc_pkg::CFG_DATA_W'(r_ib);
            salc_pkg::REG_WAYS_IN_USE:     prdata = salc_pkg::CFG_DATA_W'(r_ways);
            default:                       prdata = '0;
        endcase
    end

    // address split and configuration limits
    always_comb begin
        addr_m   = i_address[TAG_W-1:0];
        ib_eff   = (r_ib > salc_pkg::IB_W'(IB_MAX)) ? salc_pkg::IB_W'(IB_MAX) : r_ib;
        shamt    = {1'b0, r_off} + {2'b00, ib_eff};
        tag_in   = addr_m >> shamt;
        set_full = (addr_m >> r_off) & ~({TAG_W{1'b1}} << ib_eff);
        set_in   = set_full[SET_W-1:0];
        if (r_ways == '0) begin
            ways_wide = 5'd1;
        end else if ({1'b0, r_ways} > 5'(MAX_WAYS)) begin
            ways_wide = 5'(MAX_WAYS);
        end else begin
            ways_wide = {1'b0, r_ways};
        end
        ways_eff = ways_wide[WCNT_W-1:0];
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w] = (WCNT_W'(w) < ways_eff);
        end
    end

    // sequencer
    assign out_free = !r_out_valid || i_ready;
    assign in_acc   = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= salc_pkg::S_CLEAR;
            r_clr   <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == salc_pkg::S_CLEAR) begin
                r_clr <= r_clr + SET_W'(1);
            end
        end
    end

    always_comb begin
        n_state  = r_state;
        o_ready  = 1'b0;
        mem_we   = 1'b0;
        mem_wa   = r_set;
        mem_wd   = n_row;
        out_load = 1'b0;
        unique case (r_state)
            salc_pkg::S_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr;
                mem_wd = '0;
                if (r_clr == SET_LAST) begin
                    n_state = salc_pkg::S_IDLE;
                end
            end
            salc_pkg::S_IDLE: begin
                o_ready = 1'b1;
                if (i_valid) begin
                    n_state = salc_pkg::S_LOOK;
                end
            end
            salc_pkg::S_LOOK: begin
                n_state = salc_pkg::S_WRITE;
            end
            salc_pkg::S_WRITE: begin
                if (out_free) begin
                    mem_we   = 1'b1;
                    out_load = 1'b1;
                    o_ready  = 1'b1;
                    n_state  = i_valid ? salc_pkg::S_LOOK : salc_pkg::S_IDLE;
                end
            end
            default: n_state = salc_pkg::S_CLEAR;
        endcase
    end

    // set memory
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_wa] <= mem_wd;
        end
        if (in_acc) begin
            r_rd <= r_mem[set_in];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else begin
            r_fwd <= in_acc && (r_state == salc_pkg::S_WRITE) && (set_in == r_set);
        end
    end

    always_ff @(posedge i_clk) begin
        r_fwd_row <= n_row;
        if (in_acc) begin
            r_tag <= tag_in;
            r_set <= set_in;
            r_op  <= i_operation;
        end
        if (r_state == salc_pkg::S_LOOK) begin
            {r_tg, r_rk, r_d, r_v} <= row_look;
        end
    end

    assign row_look = r_fwd ? r_fwd_row : r_rd;
    assign {l_tg, l_rk, l_d, l_v} = row_look;

    salc_lookup #(
        .MAX_WAYS (MAX_WAYS),
        .TAG_W    (TAG_W),
        .RANK_W   (RANK_W),
        .WAY_W    (WAY_W),
        .WCNT_W   (WCNT_W)
    ) u_lookup (
        .i_clk        (i_clk),
        .i_en         (r_state == salc_pkg::S_LOOK),
        .i_valid_v    (l_v),
        .i_dirty_v    (l_d),
        .i_rank       (l_rk),
        .i_tags       (l_tg),
        .i_tag        (r_tag),
        .i_ways       (ways_eff),
        .i_write_back (r_wb),
        .i_operation  (r_op),
        .o_dec        (lk_dec),
        .o_way        (lk_way)
    );

    // row update
    assign touch = lk_dec.hit || lk_dec.fill;

    always_comb begin
        n_v  = r_v;
        n_d  = r_d;
        n_rk = r_rk;
        n_tg = r_tg;
        if (touch) begin
            for (int u = 0; u < MAX_WAYS; u++) begin
                if (in_use[u] && (WAY_W'(u) != lk_way) && r_v[u]) begin
                    if ((!r_v[lk_way] || (r_rk[u] < r_rk[lk_way])) && (r_rk[u] != RANK_MAX)) begin
                        n_rk[u] = r_rk[u] + RANK_W'(1);
                    end
                end
            end
            n_rk[lk_way] = '0;
            if (lk_dec.fill) begin
                n_v[lk_way]  = 1'b1;
                n_tg[lk_way] = r_tag;
                n_d[lk_way]  = r_op;
            end else if (r_wb && r_op) begin
                n_d[lk_way] = 1'b1;
            end
        end
        n_row = {n_tg, n_rk, n_d, n_v};
    end

    // result register
    assign way_ext = {3'b000, lk_way};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_hit  <= lk_dec.hit;
            r_out_way  <= way_ext[salc_pkg::WAY_OUT_W-1:0];
            r_out_refs <= lk_dec.refs;
            r_out_dev  <= lk_dec.dirty_ev;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_hit           = r_out_hit;
    assign o_way           = r_out_way;
    assign o_memory_refs   = r_out_refs;
    assign o_dirty_evicted = r_out_dev;

    `SALC_ASSERT_NXT(a_acc_to_look, in_acc, r_state == salc_pkg::S_LOOK, "transaction not looked up")
    `SALC_ASSERT_NXT(a_write_loads_out, (r_state == salc_pkg::S_WRITE) && out_free, r_out_valid, "result lost")
    `SALC_ASSERT_NOW(a_fwd_origin, r_fwd, (r_state == salc_pkg::S_LOOK) && ($past(r_state) == salc_pkg::S_WRITE), "stray forward")
    `SALC_ASSERT_NOW(a_refs_range, r_out_valid, r_out_refs <= salc_pkg::REFS_TWO, "bad reference count")
    `SALC_ASSERT_NOW(a_dev_refs, r_out_valid && r_out_dev, r_out_refs == salc_pkg::REFS_TWO, "dirty eviction without write-back")

endmodule

### rtl/salc_lookup.sv
// tag compare and victim selection over the ways of one set, registered decision
// depends on salc_pkg
module salc_lookup #(
    parameter int MAX_WAYS = salc_pkg::DEF_MAX_WAYS,
    parameter int TAG_W    = salc_pkg::DEF_ADDR_BITS,
    parameter int RANK_W   = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
    parameter int WCNT_W   = $clog2(MAX_WAYS + 1)
) (
    input  logic                             i_clk,
    input  logic                             i_en,
    input  logic [MAX_WAYS-1:0]              i_valid_v,
    input  logic [MAX_WAYS-1:0]              i_dirty_v,
    input  logic [MAX_WAYS-1:0][RANK_W-1:0]  i_rank,
    input  logic [MAX_WAYS-1:0][TAG_W-1:0]   i_tags,
    input  logic [TAG_W-1:0]                 i_tag,
    input  logic [WCNT_W-1:0]                i_ways,
    input  logic                             i_write_back,
    input  logic                             i_operation,
    output salc_pkg::t_decision              o_dec,
    output logic [WAY_W-1:0]                 o_way
);

    logic [MAX_WAYS-1:0] in_use;
    logic [MAX_WAYS-1:0] hit_vec;
    logic [MAX_WAYS-1:0] inv_vec;
    logic [MAX_WAYS-1:0] max_vec;
    logic [WAY_W-1:0]    hit_idx;
    logic [WAY_W-1:0]    inv_idx;
    logic [WAY_W-1:0]    max_idx;
    logic [WAY_W-1:0]    victim;
    salc_pkg::t_decision n_dec;
    logic [WAY_W-1:0]    n_way;
    salc_pkg::t_decision r_dec;
    logic [WAY_W-1:0]    r_way;

    always_comb begin
        for (int w = 0; w < MAX_WAYS; w++) begin
            in_use[w]  = (WCNT_W'(w) < i_ways);
            hit_vec[w] = in_use[w] && i_valid_v[w] && (i_tags[w] == i_tag);
            inv_vec[w] = in_use[w] && !i_valid_v[w];
        end
        // highest rank wins, ties go to the lowest way
        for (int w = 0; w < MAX_WAYS; w++) begin
            max_vec[w] = in_use[w];
            for (int u = 0; u < MAX_WAYS; u++) begin
                if (in_use[u] && u != w) begin
                    if (u < w) begin
                        if (i_rank[u] >= i_rank[w]) begin
                            max_vec[w] = 1'b0;
                        end
                    end else begin
                        if (i_rank[u] > i_rank[w]) begin
                            max_vec[w] = 1'b0;
                        end
                    end
                end
            end
        end
        hit_idx = '0;
        inv_idx = '0;
        max_idx = '0;
        for (int w = MAX_WAYS - 1; w >= 0; w--) begin
            if (hit_vec[w]) begin
                hit_idx = WAY_W'(w);
            end
            if (inv_vec[w]) begin
                inv_idx = WAY_W'(w);
            end
            if (max_vec[w]) begin
                max_idx = WAY_W'(w);
            end
        end
    end

    always_comb begin
        victim         = (|inv_vec) ? inv_idx : max_idx;
        n_dec.hit      = |hit_vec;
        n_dec.fill     = !n_dec.hit && (!i_operation || i_write_back);
        n_dec.dirty_ev = n_dec.fill && i_valid_v[victim] && i_dirty_v[victim];
        n_dec.refs     = salc_pkg::REFS_ONE;
        n_way          = '0;
        priority if (n_dec.hit) begin
            n_way      = hit_idx;
            n_dec.refs = i_write_back ? salc_pkg::REFS_NONE : salc_pkg::REFS_ONE;
        end else if (n_dec.fill) begin
            n_way      = victim;
            n_dec.refs = n_dec.dirty_ev ? salc_pkg::REFS_TWO : salc_pkg::REFS_ONE;
        end else begin
            n_way      = '0;
            n_dec.refs = salc_pkg::REFS_ONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_dec <= n_dec;
            r_way <= n_way;
        end
    end

    assign o_dec = r_dec;
    assign o_way = r_way;

endmodule

### tb/set_assoc_lru_cache_tags_unit_test.sv
// testbench for set_assoc_lru_cache_tags_unit: directed and random accesses under many settings,
// each result checked against a cycle-free model of tags, dirty bits and lru ranks
// depends on salc_pkg and the rtl of set_assoc_lru_cache_tags_unit
module set_assoc_lru_cache_tags_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SETS     = salc_pkg::DEF_MAX_SETS;
    localparam int NUM_WAYS     = salc_pkg::DEF_MAX_WAYS;
    localparam int NUM_LINES    = NUM_SETS * NUM_WAYS;
    localparam int MAX_IB       = $clog2(NUM_SETS + 1) - 1;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int PHASE_ITEMS  = 165;
    localparam int NUM_PHASES   = 9;
    localparam logic OP_READ    = 1'b0;
    localparam logic OP_WRITE   = 1'b1;

    // write_back_mode, offset_bits, index_bits, ways_in_use
    localparam int PHASE_CFG [NUM_PHASES][4] = '{
        '{1, 4, 2, 4}, '{0, 4, 2, 4}, '{1, 0, 8, 8},
        '{0, 16, 0, 1}, '{1, 31, 15, 15}, '{1, 2, 3, 0},
        '{0, 5, 1, 8}, '{1, 6, 4, 3}, '{1, 4, 0, 2}
    };

    typedef struct packed {
        logic                           hit;
        logic [salc_pkg::WAY_OUT_W-1:0] way;
        logic [salc_pkg::REFS_W-1:0]    refs;
        logic                           dirty_ev;
    } t_access_result;

    class cache_tag_scoreboard;
        bit             tag_valid [NUM_LINES];
        bit [31:0]      tag_value [NUM_LINES];
        bit             tag_dirty [NUM_LINES];
        bit [2:0]       age_rank [NUM_LINES];
        bit             wb_mode;
        bit [salc_pkg::OFF_W-1:0]  offset_w;
        bit [salc_pkg::IB_W-1:0]   index_w;
        bit [salc_pkg::WAYS_W-1:0] ways_raw;
        t_access_result expected_q [$];
        int             error_count;
        int             result_count;

        function new();
            wb_mode = 1'b0;
            offset_w = salc_pkg::OFF_RESET;
            index_w = salc_pkg::IB_RESET;
            ways_raw = salc_pkg::WAYS_RESET;
            error_count = 0;
            result_count = 0;
        endfunction

        function void set_config(bit wb, bit [salc_pkg::OFF_W-1:0] ob,
                                 bit [salc_pkg::IB_W-1:0] ib,
                                 bit [salc_pkg::WAYS_W-1:0] nways);
            wb_mode = wb;
            offset_w = ob;
            index_w = ib;
            ways_raw = nways;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void promote_way(int base, int nways, int w);
            int  v;
            int  old_rank;
            bit  was_valid;
            old_rank = age_rank[base + w];
            was_valid = tag_valid[base + w];
            for (v = 0; v < nways; v++) begin
                if (v != w && tag_valid[base + v] &&
                    (!was_valid || age_rank[base + v] < old_rank) &&
                    age_rank[base + v] < NUM_WAYS - 1) begin
                    age_rank[base + v]++;
                end
            end
            age_rank[base + w] = 3'd0;
        endfunction

        function t_access_result predict_access(bit is_write, bit [salc_pkg::ADDR_W-1:0] addr);
            t_access_result r;
            int        eib;
            int        nways;
            int        base;
            int        victim;
            int        w;
            bit [63:0] a64;
            bit [31:0] tag;
            bit        found;
            eib = (index_w > MAX_IB) ? MAX_IB : int'(index_w);
            nways = (ways_raw == 0) ? 1 : ((ways_raw > NUM_WAYS) ? NUM_WAYS : int'(ways_raw));
            a64 = {32'd0, addr};
            tag = 32'(a64 >> (offset_w + eib));
            base = int'((a64 >> offset_w) & ((64'd1 << eib) - 64'd1)) * NUM_WAYS;
            r = '0;
            found = 1'b0;
            for (w = 0; w < nways && !found; w++) begin
                if (tag_valid[base + w] && tag_value[base + w] == tag) begin
                    found = 1'b1;
                    r.way = 3'(w);
                end
            end
            r.hit = found;
            if (found) begin
                promote_way(base, nways, int'(r.way));
                if (wb_mode) begin
                    if (is_write)
                        tag_dirty[base + r.way] = 1'b1;
                end else begin
                    r.refs = salc_pkg::REFS_ONE;
                end
            end else if (is_write && !wb_mode) begin
                // write-through miss without allocation
                r.refs = salc_pkg::REFS_ONE;
                r.way = 3'd0;
            end else begin
                victim = -1;
                for (w = 0; w < nways; w++) begin
                    if (!tag_valid[base + w] && victim < 0)
                        victim = w;
                end
                if (victim < 0) begin
                    victim = 0;
                    for (w = 1; w < nways; w++) begin
                        if (age_rank[base + w] > age_rank[base + victim])
                            victim = w;
                    end
                end
                r.refs = salc_pkg::REFS_ONE;
                if (tag_valid[base + victim] && tag_dirty[base + victim]) begin
                    r.dirty_ev = 1'b1;
                    r.refs = salc_pkg::REFS_TWO;
                end
                promote_way(base, nways, victim);
                tag_valid[base + victim] = 1'b1;
                tag_value[base + victim] = tag;
                tag_dirty[base + victim] = is_write;
                r.way = 3'(victim);
            end
            return r;
        endfunction

        function void note_access(bit is_write, bit [salc_pkg::ADDR_W-1:0] addr);
            expected_q.push_back(predict_access(is_write, addr));
        endfunction

        task report_mismatch(string what, logic [31:0] got, logic [31:0] exp_v);
            error_count++;
            if (error_count <= 100)
                $display("mismatch at result %0d: %s got %0h expected %0h",
                         result_count, what, got, exp_v);
        endtask

        task check_result(logic hit, logic [salc_pkg::WAY_OUT_W-1:0] way,
                          logic [salc_pkg::REFS_W-1:0] refs, logic dirty_ev);
            t_access_result exp_v;
            result_count++;
            if (expected_q.size() == 0) begin
                report_mismatch("result with no access pending", 32'd0, 32'd0);
            end else begin
                exp_v = expected_q.pop_front();
                if (hit !== exp_v.hit)
                    report_mismatch("hit", 32'(hit), 32'(exp_v.hit));
                if (way !== exp_v.way)
                    report_mismatch("way", 32'(way), 32'(exp_v.way));
                if (refs !== exp_v.refs)
                    report_mismatch("memory_refs", 32'(refs), 32'(exp_v.refs));
                if (dirty_ev !== exp_v.dirty_ev)
                    report_mismatch("dirty_evicted", 32'(dirty_ev), 32'(exp_v.dirty_ev));
            end
        endtask
    endclass

    logic                             i_clk = 1'b0;
    logic                             i_rst_n = 1'b0;
    logic                             psel = 1'b0;
    logic                             penable = 1'b0;
    logic                             pwrite = 1'b0;
    logic [salc_pkg::CFG_ADDR_W-1:0]  paddr = '0;
    logic [salc_pkg::CFG_DATA_W-1:0]  pwdata = '0;
    logic [salc_pkg::CFG_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             i_valid = 1'b0;
    logic                             o_ready;
    logic                             i_operation = 1'b0;
    logic [salc_pkg::ADDR_W-1:0]      i_address = '0;
    logic                             o_valid;
    logic                             i_ready = 1'b0;
    logic                             o_hit;
    logic [salc_pkg::WAY_OUT_W-1:0]   o_way;
    logic [salc_pkg::REFS_W-1:0]      o_memory_refs;
    logic                             o_dirty_evicted;

    int                     send_idle_pct = 7;
    int                     recv_stall_pct = 83;
    int unsigned            cycle_count = 0;
    cache_tag_scoreboard    sb;

    set_assoc_lru_cache_tags_unit u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .i_valid         (i_valid),
        .o_ready         (o_ready),
        .i_operation     (i_operation),
        .i_address       (i_address),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_hit           (o_hit),
        .o_way           (o_way),
        .o_memory_refs   (o_memory_refs),
        .o_dirty_evicted (o_dirty_evicted)
    );

    always #10 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_valid && i_ready)
                sb.check_result(o_hit, o_way, o_memory_refs, o_dirty_evicted);
            i_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    task automatic wait_idle();
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_reg(input salc_pkg::t_reg_idx idx,
                             input logic [salc_pkg::CFG_DATA_W-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= salc_pkg::CFG_ADDR_W'(4 * int'(idx));
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
    endtask

    task automatic apply_config(input bit wb, input bit [salc_pkg::OFF_W-1:0] ob,
                                input bit [salc_pkg::IB_W-1:0] ib,
                                input bit [salc_pkg::WAYS_W-1:0] nways);
        wait_idle();
        write_reg(salc_pkg::REG_WRITE_BACK_MODE, salc_pkg::CFG_DATA_W'(wb));
        write_reg(salc_pkg::REG_OFFSET_BITS, salc_pkg::CFG_DATA_W'(ob));
        write_reg(salc_pkg::REG_INDEX_BITS, salc_pkg::CFG_DATA_W'(ib));
        write_reg(salc_pkg::REG_WAYS_IN_USE, salc_pkg::CFG_DATA_W'(nways));
        psel <= 1'b0;
        penable <= 1'b0;
        sb.set_config(wb, ob, ib, nways);
    endtask

    task automatic send_access(input logic op, input logic [salc_pkg::ADDR_W-1:0] addr);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_operation <= op;
        i_address <= addr;
        do @(posedge i_clk); while (!o_ready);
        sb.note_access(op, addr);
    endtask

    task automatic run_random_phase(input int p);
        int          ob;
        int          eib;
        int          nways;
        int          n;
        int          set_sel;
        logic [31:0] tag_base;
        logic [31:0] tag;
        logic [63:0] a64;
        logic [salc_pkg::ADDR_W-1:0] addr;
        apply_config(PHASE_CFG[p][0], PHASE_CFG[p][1], PHASE_CFG[p][2], PHASE_CFG[p][3]);
        ob = PHASE_CFG[p][1];
        eib = (PHASE_CFG[p][2] > MAX_IB) ? MAX_IB : PHASE_CFG[p][2];
        nways = (PHASE_CFG[p][3] == 0) ? 1 :
                ((PHASE_CFG[p][3] > NUM_WAYS) ? NUM_WAYS : PHASE_CFG[p][3]);
        tag_base = $urandom;
        for (n = 0; n < PHASE_ITEMS; n++) begin
            // hold off until the block drains completely
            if (n == PHASE_ITEMS / 2)
                wait_idle();
            if ($urandom_range(0, 99) < 12) begin
                addr = $urandom;
            end else begin
                // few tags over few sets so lines hit, age and get evicted
                tag = tag_base + $urandom_range(0, nways + 2);
                set_sel = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 3) : int'($urandom);
                a64 = (64'(tag) << (ob + eib)) |
                      ((64'(set_sel) & ((64'd1 << eib) - 64'd1)) << ob) |
                      (64'($urandom) & ((64'd1 << ob) - 64'd1));
                addr = a64[salc_pkg::ADDR_W-1:0];
            end
            send_access(logic'($urandom_range(0, 1)), addr);
        end
    endtask

    initial begin
        int p;
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // write-back hits, dirty fills and a dirty eviction
        apply_config(1'b1, 5'd4, 4'd0, 4'd2);
        send_access(OP_READ, 32'h0000_0000);
        send_access(OP_READ, 32'h0000_0000);
        send_access(OP_WRITE, 32'h0000_0010);
        send_access(OP_WRITE, 32'h0000_0010);
        send_access(OP_READ, 32'h0000_0020);
        send_access(OP_READ, 32'h0000_0030);
        send_access(OP_READ, 32'hFFFF_FFF0);
        send_access(OP_WRITE, 32'hFFFF_FFFF);
        // write-through on the same lines
        apply_config(1'b0, 5'd4, 4'd0, 4'd2);
        send_access(OP_READ, 32'hFFFF_FFFF);
        send_access(OP_WRITE, 32'h0000_0100);
        send_access(OP_READ, 32'h0000_0100);
        send_access(OP_WRITE, 32'h0000_0100);
        // duplicate tags in one set by shrinking the ways, then equal ranks
        apply_config(1'b1, 5'd4, 4'd1, 4'd2);
        send_access(OP_READ, 32'h0000_0030);
        send_access(OP_READ, 32'h0000_0050);
        apply_config(1'b1, 5'd4, 4'd1, 4'd1);
        send_access(OP_READ, 32'h0000_0050);
        apply_config(1'b1, 5'd4, 4'd1, 4'd2);
        send_access(OP_READ, 32'h0000_0050);
        send_access(OP_READ, 32'h0000_0070);
        // offset, index and ways beyond their ranges
        apply_config(1'b1, 5'd31, 4'd15, 4'd15);
        send_access(OP_READ, 32'h1234_5678);
        send_access(OP_WRITE, 32'h8000_0000);
        send_access(OP_READ, 32'hFFFF_FFFF);
        apply_config(1'b0, 5'd16, 4'd8, 4'd0);
        send_access(OP_READ, 32'hABCD_0000);
        send_access(OP_READ, 32'hABCD_1234);
        send_access(OP_WRITE, 32'h0001_0000);

        for (p = 0; p < NUM_PHASES; p++) begin
            send_idle_pct = (p < 3) ? 7 : ((p < 6) ? 83 : 0);
            recv_stall_pct = (p < 3) ? 83 : ((p < 6) ? 7 : 0);
            run_random_phase(p);
        end

        wait_idle();
        repeat (8) @(posedge i_clk);
        if (sb.error_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
